// ===== hdl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Types, character codes and helpers shared by the byte literal escaper.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int RUN_MAX = 6;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  typedef logic [6:0] char_t;
  typedef logic [7:0] byte_t;
  typedef logic [RUN_CNT_W-1:0] run_cnt_t;
  typedef logic [RUN_IDX_W-1:0] run_idx_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam byte_t PRINT_LOW  = 8'd32;
  localparam byte_t PRINT_HIGH = 8'd126;
  localparam byte_t BYTE_TAB   = 8'h09;
  localparam byte_t BYTE_LF    = 8'h0a;
  localparam byte_t BYTE_CR    = 8'h0d;
  localparam byte_t BYTE_BSL   = 8'h5c;

  localparam char_t CH_B   = 7'h62;
  localparam char_t CH_SQ  = 7'h27;
  localparam char_t CH_DQ  = 7'h22;
  localparam char_t CH_BSL = 7'h5c;
  localparam char_t CH_N   = 7'h6e;
  localparam char_t CH_R   = 7'h72;
  localparam char_t CH_T   = 7'h74;
  localparam char_t CH_X   = 7'h78;

  typedef struct packed {
    logic  kind;
    byte_t byte_value;
  } item_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][6:0] chars;
    run_cnt_t                cnt;
    logic                    closes;
  } run_t;

  function automatic char_t hex_digit(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// ===== hdl/ble_in_if.sv =====
// ----------------------------------------------------------------------------
// ble_in_if
// Input channel: raw bytes and end-of-literal marks.
// ----------------------------------------------------------------------------
interface ble_in_if;
  logic         valid;
  logic         ready;
  logic         kind;
  logic [7:0]   byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// ===== hdl/ble_out_if.sv =====
// ----------------------------------------------------------------------------
// ble_out_if
// Output channel: one printable character per transfer.
// ----------------------------------------------------------------------------
interface ble_out_if;
  logic         valid;
  logic         ready;
  logic [6:0]   char_out;
  logic         last_of_run;
  logic         literal_done;

  modport source (output valid, output char_out, output last_of_run,
                  output literal_done, input ready);
  modport sink   (input valid, input char_out, input last_of_run,
                  input literal_done, output ready);
endinterface

// ===== hdl/byte_literal_escaper.sv =====
// ----------------------------------------------------------------------------
// byte_literal_escaper
// Turns raw bytes into a printable bytes literal, one character per transfer.
// ----------------------------------------------------------------------------
// Channels: bytes carries items (kind = data byte or end of literal); chars
// carries one ASCII character per transfer, with last_of_run on the final
// character of an item and literal_done on the closing quote.
// cfg_wr_en / cfg_wr_data set the quote: 0 = single, 1 = double. Write it
// only while the block is idle.
// With the run register free, the first character of an item passes
// through the input register, then the run register, before it is valid
// on chars.
// An item occupies the run register until all of its characters have
// transferred: 1 for a plain byte or an end mark, 2 for a short escape,
// 4 for a hex escape, plus 2 when it opens a literal. The single character
// output port sets that pace; the input register takes the next item
// meanwhile.
// Reset: no literal is open and the quote is single.
// Stall: when chars.ready is low the current character holds, the run
// register holds, and bytes.ready drops once the input register is full.
// ----------------------------------------------------------------------------
module byte_literal_escaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  ble_in_if.sink      bytes,
  ble_out_if.source   chars
);

  logic             use_double_quote;
  logic             held;
  logic             take;
  logic             literal_open;
  ble_pkg::item_t   item;
  ble_pkg::run_t    run;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_double_quote <= 1'b0;
    end else if (cfg_wr_en) begin
      use_double_quote <= cfg_wr_data;
    end
  end

  ble_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .held  (held),
    .item  (item)
  );

  ble_escape u_escape (
    .item             (item),
    .literal_open     (literal_open),
    .use_double_quote (use_double_quote),
    .run              (run)
  );

  ble_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .held         (held),
    .run_in       (run),
    .take         (take),
    .literal_open (literal_open),
    .chars        (chars)
  );

endmodule

// ===== hdl/ble_in_stage.sv =====
// ----------------------------------------------------------------------------
// ble_in_stage
// Input register: holds one accepted item until the run buffer takes it.
// ----------------------------------------------------------------------------
module ble_in_stage (
  input  logic             clk,
  input  logic             rst,
  ble_in_if.sink           bytes,
  input  logic             take,
  output logic             held,
  output ble_pkg::item_t   item
);

  logic in_v;
  logic in_v_next;

  assign bytes.ready = !in_v || take;
  assign held        = in_v;

  always_comb begin
    in_v_next = in_v;
    if (bytes.valid && bytes.ready) begin
      in_v_next = 1'b1;
    end else if (take) begin
      in_v_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= in_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.kind       <= bytes.kind;
      item.byte_value <= bytes.byte_value;
    end
  end

endmodule

// ===== hdl/ble_escape.sv =====
// ----------------------------------------------------------------------------
// ble_escape
// Maps one item to its character run: optional b-prefix and opening quote,
// then the escaped byte or the closing quote.
// ----------------------------------------------------------------------------
module ble_escape (
  input  ble_pkg::item_t  item,
  input  logic            literal_open,
  input  logic            use_double_quote,
  output ble_pkg::run_t   run
);

  ble_pkg::char_t         q;
  ble_pkg::char_t [3:0]   body;
  logic [2:0]             body_n;

  assign q = use_double_quote ? ble_pkg::CH_DQ : ble_pkg::CH_SQ;

  always_comb begin
    body   = '{default: ble_pkg::CH_BSL};
    body_n = 3'd2;
    if (item.kind == ble_pkg::KIND_END) begin
      body[0] = q;
      body_n  = 3'd1;
    end else if (item.byte_value == ble_pkg::BYTE_LF) begin
      body[1] = ble_pkg::CH_N;
    end else if (item.byte_value == ble_pkg::BYTE_CR) begin
      body[1] = ble_pkg::CH_R;
    end else if (item.byte_value == ble_pkg::BYTE_TAB) begin
      body[1] = ble_pkg::CH_T;
    end else if (item.byte_value == ble_pkg::BYTE_BSL) begin
      body[1] = ble_pkg::CH_BSL;
    end else if (item.byte_value == {1'b0, q}) begin
      body[1] = q;
    end else if (item.byte_value inside {[ble_pkg::PRINT_LOW:ble_pkg::PRINT_HIGH]}) begin
      body[0] = item.byte_value[6:0];
      body_n  = 3'd1;
    end else begin
      body[1] = ble_pkg::CH_X;
      body[2] = ble_pkg::hex_digit(item.byte_value[7:4]);
      body[3] = ble_pkg::hex_digit(item.byte_value[3:0]);
      body_n  = 3'd4;
    end
  end

  always_comb begin
    run.closes = (item.kind == ble_pkg::KIND_END);
    run.chars  = '{default: ble_pkg::CH_BSL};
    if (literal_open) begin
      for (int i = 0; i < 4; i++) begin
        run.chars[i] = body[i];
      end
      run.cnt = ble_pkg::RUN_CNT_W'(body_n);
    end else begin
      run.chars[0] = ble_pkg::CH_B;
      run.chars[1] = q;
      for (int i = 0; i < 4; i++) begin
        run.chars[i+2] = body[i];
      end
      run.cnt = ble_pkg::RUN_CNT_W'(body_n) + ble_pkg::RUN_CNT_W'(2);
    end
  end

endmodule

// ===== hdl/ble_serializer.sv =====
// ----------------------------------------------------------------------------
// ble_serializer
// Run register: holds one character run and hands it out one character per
// transfer; tracks whether a literal is open.
// ----------------------------------------------------------------------------
module ble_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            held,
  input  ble_pkg::run_t   run_in,
  output logic            take,
  output logic            literal_open,
  ble_out_if.source       chars
);

  logic                             seq_v;
  logic [ble_pkg::RUN_MAX-1:0][6:0] seq_chars;
  ble_pkg::run_cnt_t                seq_cnt;
  ble_pkg::run_idx_t                idx;
  logic                             seq_closes;
  logic                             at_last;
  logic                             xfer;

  assign at_last = (ble_pkg::RUN_CNT_W'(idx) + ble_pkg::RUN_CNT_W'(1)) == seq_cnt;
  assign xfer    = chars.valid && chars.ready;
  assign take    = held && (!seq_v || (xfer && at_last));

  assign chars.valid        = seq_v;
  assign chars.char_out     = seq_chars[idx];
  assign chars.last_of_run  = at_last;
  assign chars.literal_done = at_last && seq_closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_v        <= 1'b0;
      idx          <= '0;
      literal_open <= 1'b0;
    end else if (take) begin
      seq_v        <= 1'b1;
      idx          <= '0;
      literal_open <= !run_in.closes;
    end else if (xfer) begin
      if (at_last) begin
        seq_v <= 1'b0;
      end
      idx <= idx + ble_pkg::RUN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq_chars  <= run_in.chars;
      seq_cnt    <= run_in.cnt;
      seq_closes <= run_in.closes;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    seq_v |-> (ble_pkg::RUN_CNT_W'(idx) < seq_cnt))
    else $error("run index past run length");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    take |-> (run_in.cnt >= ble_pkg::RUN_CNT_W'(1) &&
              run_in.cnt <= ble_pkg::RUN_CNT_W'(ble_pkg::RUN_MAX)))
    else $error("run length out of range");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    (xfer && chars.literal_done) |=> !literal_open || seq_v)
    else $error("literal still open after closing quote");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (xfer && !at_last) |=> (seq_v && idx == $past(idx) + ble_pkg::RUN_IDX_W'(1)))
    else $error("run did not advance");

endmodule

// ===== tb/byte_literal_escaper_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_literal_escaper_test
// Self-checking bench for the byte literal escaper. A directed table covers
// byte extremes, every escape, both quote settings, empty literals and a
// quote change while a literal is open. Random literals follow under three
// backpressure patterns. Every character is checked against a local model.
// ----------------------------------------------------------------------------
module byte_literal_escaper_test;

  localparam bit QUOTE_SINGLE = 1'b0;
  localparam bit QUOTE_DOUBLE = 1'b1;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 73;
  localparam int SHOW_MAX     = 10;

  typedef struct {
    bit             quote;
    logic           kind;
    ble_pkg::byte_t value;
    string          text;
  } dir_row_t;

  typedef struct packed {
    ble_pkg::char_t ch;
    logic           last;
    logic           done;
  } char_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  ble_in_if  bytes_if ();
  ble_out_if chars_if ();

  byte_literal_escaper u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (bytes_if),
    .chars       (chars_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_rec_t pending_chars[$];
  bit        quote_sel = QUOTE_SINGLE;
  bit        literal_open = 1'b0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        errors = 0;
  int        items_sent = 0;
  int        chars_seen = 0;
  int        literals_closed = 0;
  int        quiet_cycles = 0;
  int        lit_left = 0;

  dir_row_t directed_rows [22] = '{
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h00, "b'\\x00"},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'hff, "\\xff"},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h20, " "},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h7e, "~"},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h1f, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h7f, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, ble_pkg::BYTE_LF, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, ble_pkg::BYTE_CR, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, ble_pkg::BYTE_TAB, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, ble_pkg::BYTE_BSL, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, {1'b0, ble_pkg::CH_SQ}, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, {1'b0, ble_pkg::CH_DQ}, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h41, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h80, ""},
    '{QUOTE_SINGLE, ble_pkg::KIND_END,  8'h00, "'"},
    '{QUOTE_SINGLE, ble_pkg::KIND_END,  8'hff, "b''"},
    '{QUOTE_SINGLE, ble_pkg::KIND_DATA, 8'h7a, ""},
    '{QUOTE_DOUBLE, ble_pkg::KIND_DATA, {1'b0, ble_pkg::CH_DQ}, "\\\""},
    '{QUOTE_DOUBLE, ble_pkg::KIND_DATA, {1'b0, ble_pkg::CH_SQ}, ""},
    '{QUOTE_DOUBLE, ble_pkg::KIND_END,  8'h00, "\""},
    '{QUOTE_DOUBLE, ble_pkg::KIND_END,  8'h00, "b\"\""},
    '{QUOTE_DOUBLE, ble_pkg::KIND_DATA, ble_pkg::BYTE_LF, ""}
  };

  function automatic ble_pkg::char_t to_hex(input logic [3:0] nib);
    ble_pkg::byte_t code;
    if (nib < 4'd10) begin
      code = 8'h30 + {4'h0, nib};
    end else begin
      code = 8'h61 + {4'h0, nib} - 8'd10;
    end
    return code[6:0];
  endfunction

  // Expected characters for one input transfer; a typed text overrides
  // the computed characters, state still follows the computation.
  task automatic escape_item(input logic kind, input ble_pkg::byte_t value,
                             input string text);
    ble_pkg::char_t q;
    ble_pkg::char_t run[$];
    ble_pkg::byte_t tch;
    char_rec_t      rec;
    q = quote_sel ? ble_pkg::CH_DQ : ble_pkg::CH_SQ;
    if (!literal_open) begin
      run.push_back(ble_pkg::CH_B);
      run.push_back(q);
      literal_open = 1'b1;
    end
    if (kind == ble_pkg::KIND_END) begin
      run.push_back(q);
      literal_open = 1'b0;
    end else if (value == ble_pkg::BYTE_LF) begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(ble_pkg::CH_N);
    end else if (value == ble_pkg::BYTE_CR) begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(ble_pkg::CH_R);
    end else if (value == ble_pkg::BYTE_TAB) begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(ble_pkg::CH_T);
    end else if (value == ble_pkg::BYTE_BSL) begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(ble_pkg::CH_BSL);
    end else if (value == {1'b0, q}) begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(q);
    end else if (value >= ble_pkg::PRINT_LOW && value <= ble_pkg::PRINT_HIGH) begin
      run.push_back(value[6:0]);
    end else begin
      run.push_back(ble_pkg::CH_BSL);
      run.push_back(ble_pkg::CH_X);
      run.push_back(to_hex(value[7:4]));
      run.push_back(to_hex(value[3:0]));
    end
    if (text.len() != 0) begin
      run.delete();
      for (int i = 0; i < text.len(); i++) begin
        tch = text[i];
        run.push_back(tch[6:0]);
      end
    end
    for (int i = 0; i < run.size(); i++) begin
      rec.ch = run[i];
      rec.last = (i == run.size() - 1);
      rec.done = (kind == ble_pkg::KIND_END) && rec.last;
      pending_chars.push_back(rec);
    end
  endtask

  task automatic send_item(input logic kind, input ble_pkg::byte_t value,
                           input string text);
    while ($urandom_range(99) < send_idle) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.kind <= kind;
    bytes_if.byte_value <= value;
    do @(posedge clk); while (!bytes_if.ready);
    escape_item(kind, value, text);
    items_sent++;
  endtask

  // Drain all expected characters, then give the pipeline time to go idle.
  task automatic settle();
    bytes_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quote(input bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    quote_sel = v;
  endtask

  function automatic ble_pkg::byte_t pick_byte();
    ble_pkg::byte_t specials [6] = '{ble_pkg::BYTE_LF, ble_pkg::BYTE_CR,
                                     ble_pkg::BYTE_TAB, ble_pkg::BYTE_BSL,
                                     {1'b0, ble_pkg::CH_SQ}, {1'b0, ble_pkg::CH_DQ}};
    ble_pkg::byte_t edges [7] = '{8'h00, 8'hff, 8'h20, 8'h7e, 8'h1f, 8'h7f, 8'h80};
    int             r;
    r = $urandom_range(9);
    if (r == 0) begin
      return specials[$urandom_range(5)];
    end else if (r == 1) begin
      return edges[$urandom_range(6)];
    end else if (r < 6) begin
      return ble_pkg::byte_t'($urandom_range(126, 32));
    end
    return ble_pkg::byte_t'($urandom_range(255));
  endfunction

  task automatic report_error(input string what, input char_rec_t want, input char_rec_t got);
    if (errors < SHOW_MAX) begin
      $display("%0t: %s: expected ch=%h last=%b done=%b, got ch=%h last=%b done=%b",
               $realtime, what, want.ch, want.last, want.done, got.ch, got.last, got.done);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    chars_if.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    char_rec_t got;
    char_rec_t want;
    if (!rst && chars_if.valid && chars_if.ready) begin
      got = '{chars_if.char_out, chars_if.last_of_run, chars_if.literal_done};
      chars_seen++;
      if (chars_if.literal_done) literals_closed++;
      if (pending_chars.size() == 0) begin
        report_error("unexpected transfer", '0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got !== want) report_error("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (chars_if.valid && chars_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("byte_literal_escaper_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic           kind;
    ble_pkg::byte_t value;
    bytes_if.valid = 1'b0;
    bytes_if.kind = ble_pkg::KIND_DATA;
    bytes_if.byte_value = 8'h00;
    chars_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 22;
    recv_idle = 73;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].quote != quote_sel) begin
        settle();
        write_quote(directed_rows[i].quote);
      end
      send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].text);
    end

    // literals run across segment boundaries, so the quote often flips mid-literal
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg / 2)
        0: begin send_idle = 22; recv_idle = 73; end
        1: begin send_idle = 73; recv_idle = 22; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_quote(seg % 2 == 0 ? QUOTE_SINGLE : QUOTE_DOUBLE);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (lit_left == 0 || $urandom_range(19) == 0) begin
          kind = ble_pkg::KIND_END;
          lit_left = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          kind = ble_pkg::KIND_DATA;
          lit_left--;
        end
        value = (kind == ble_pkg::KIND_END) ? ble_pkg::byte_t'($urandom_range(255))
                                            : pick_byte();
        send_item(kind, value, "");
      end
    end

    settle();
    repeat (20) @(posedge clk);
    errors += pending_chars.size();
    $display("%0d items sent, %0d characters checked, %0d literals closed",
             items_sent, chars_seen, literals_closed);
    $display("both quote settings, mid-literal quote changes, three stall patterns");
    if (errors == 0) begin
      $display("byte_literal_escaper_test: done, clean");
    end else begin
      $display("byte_literal_escaper_test: done, errors");
    end
    $finish;
  end

endmodule
